[design/rlpr_pkg.sv]
// ----------------------------------------------------------------------------
// rlpr_pkg
// shared types and constants of the region lookup-table pixel remap block
// ----------------------------------------------------------------------------
package rlpr_pkg;

  localparam int TABLE_COUNT_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int TABLE_ENTRIES   = 256;
  localparam int MAX_POINTS      = 256;
  localparam int POINT_W         = 17;
  localparam int COUNT_W         = 9;
  localparam int TBL_FIELD_W     = 5;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic {
    KIND_PIXEL,
    KIND_FINISH
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_FILTER = 2'd1,
    STATUS_FEW_POINTS = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_RUN,
    ST_RB_A,
    ST_RB_B,
    ST_RB_C,
    ST_RB_S,
    ST_RB_W,
    ST_CK_A,
    ST_CK_B,
    ST_CK_C,
    ST_CK_S,
    ST_STATUS
  } back_state_e;

  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             pix;
    logic [TBL_FIELD_W-1:0] tbl;
    status_e                status;
    logic [7:0]             nm1;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic load_done;
  } back_stat_t;

  function automatic int raw_width(int frac_bits);
    return (frac_bits + 1 > POINT_W) ? frac_bits + 1 : POINT_W;
  endfunction

endpackage

[design/rlpr_ram.sv]
// ----------------------------------------------------------------------------
// rlpr_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rlpr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[design/rlpr_queue.sv]
// ----------------------------------------------------------------------------
// rlpr_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module rlpr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rlpr_pkg::cmd_t data_i,
  input  logic          pop_i,
  output rlpr_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int PtrW = $clog2(rlpr_pkg::QUEUE_DEPTH);

  rlpr_pkg::cmd_t  mem_q [rlpr_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == (PtrW+1)'(rlpr_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

[design/rlpr_front.sv]
// ----------------------------------------------------------------------------
// rlpr_front
// accepts items, gathers breakpoints and classifies commands for the back
// ----------------------------------------------------------------------------
module rlpr_front #(
  parameter int TABLE_COUNT = rlpr_pkg::TABLE_COUNT_DEF,
  parameter int FRAC_BITS   = rlpr_pkg::FRAC_BITS_DEF,
  parameter int RawW        = rlpr_pkg::raw_width(FRAC_BITS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  logic                   op_i,
  input  logic [7:0]             pixel_i,
  input  logic [7:0]             region_i,
  input  logic [7:0]             filter_i,
  input  logic [16:0]            point_i,
  input  logic                   last_i,
  input  rlpr_pkg::back_stat_t   back_stat_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output rlpr_pkg::cmd_t         q_cmd_o,
  output logic                   pb_we_o,
  output logic [7:0]             pb_waddr_o,
  output logic [RawW-1:0]        pb_wdata_o
);

  localparam logic [RawW-1:0] OneQ = {{(RawW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam int CW = rlpr_pkg::COUNT_W;

  logic          pending_q, pending_d;
  logic [CW-1:0] count_q, count_d, count_inc;
  logic [7:0]    filter_q, filter_d, filt_eff;
  logic          accept, load;
  logic [RawW-1:0] pv_ext;

  assign s_ready_o = !back_stat_i.clearing && !q_full_i && !pending_q;
  assign accept    = s_valid_i && s_ready_o;
  assign load      = accept && op_i;

  assign pv_ext    = RawW'(point_i);
  assign filt_eff  = (count_q == '0) ? filter_i : filter_q;
  assign count_inc = (count_q < CW'(rlpr_pkg::MAX_POINTS)) ? count_q + 1'b1 : count_q;

  assign pb_we_o    = load && (count_q < CW'(rlpr_pkg::MAX_POINTS));
  assign pb_waddr_o = count_q[7:0];
  assign pb_wdata_o = (pv_ext > OneQ) ? OneQ : pv_ext;

  assign q_push_o = accept && (!op_i || last_i);

  always_comb begin
    q_cmd_o = '0;
    if (!op_i) begin
      q_cmd_o.kind = rlpr_pkg::KIND_PIXEL;
      q_cmd_o.pix  = pixel_i;
      if ({1'b0, region_i[4:0]} < 6'(TABLE_COUNT)) begin
        q_cmd_o.tbl = region_i[4:0];
      end
    end else begin
      q_cmd_o.kind = rlpr_pkg::KIND_FINISH;
      q_cmd_o.tbl  = filt_eff[4:0];
      q_cmd_o.nm1  = 8'(count_inc - 1'b1);
      if (count_inc < CW'(2)) begin
        q_cmd_o.status = rlpr_pkg::STATUS_FEW_POINTS;
      end else if (filt_eff >= 8'(TABLE_COUNT)) begin
        q_cmd_o.status = rlpr_pkg::STATUS_BAD_FILTER;
      end else begin
        q_cmd_o.status = rlpr_pkg::STATUS_OK;
      end
    end
  end

  always_comb begin
    pending_d = pending_q;
    count_d   = count_q;
    filter_d  = filter_q;
    if (back_stat_i.load_done) begin
      pending_d = 1'b0;
    end
    if (load) begin
      filter_d = filt_eff;
      if (last_i) begin
        count_d   = '0;
        pending_d = 1'b1;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      count_q   <= '0;
      filter_q  <= '0;
    end else begin
      pending_q <= pending_d;
      count_q   <= count_d;
      filter_q  <= filter_d;
    end
  end

endmodule

[design/rlpr_back.sv]
// ----------------------------------------------------------------------------
// rlpr_back
// table lookups, table rebuild and cooking sequencer, result stage
// ----------------------------------------------------------------------------
module rlpr_back #(
  parameter int TABLE_COUNT = rlpr_pkg::TABLE_COUNT_DEF,
  parameter int FRAC_BITS   = rlpr_pkg::FRAC_BITS_DEF,
  parameter int RawW        = rlpr_pkg::raw_width(FRAC_BITS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rlpr_pkg::cmd_t       cmd_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 pb_re_o,
  output logic [7:0]           pb_raddr_o,
  input  logic [RawW-1:0]      pb_rdata_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [7:0]           mapped_o,
  output logic [1:0]           status_o,
  output logic                 is_status_o,
  output rlpr_pkg::back_stat_t stat_o
);

  localparam int TblW  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int AddrW = TblW + 8;
  localparam int Depth = TABLE_COUNT * rlpr_pkg::TABLE_ENTRIES;
  localparam int ProdW = 2 * RawW;
  localparam int VW    = ProdW + 8;
  localparam logic [RawW-1:0] OneQ  = {{(RawW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [VW-1:0]   HalfV = {{(VW-1){1'b0}}, 1'b1} << (2*FRAC_BITS-1);

  rlpr_pkg::back_state_e state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [7:0]        i_q, i_d, nm1_q, nm1_d;
  logic [15:0]       t_q, t_d;
  logic [TblW-1:0]   f_q, f_d, tbl_q, tbl_d;
  logic [RawW-1:0]   a_q, a_d, b_q, b_d, g_q, g_d;
  logic [RawW+8:0]   p1_q, p1_d;
  logic [RawW+9:0]   sum_q, sum_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic              s1_valid_q, s1_valid_d, s1_is_q, s1_is_d;
  logic [1:0]        s1_code_q, s1_code_d;
  logic              out_valid_q, out_valid_d, out_is_q, out_is_d;
  logic [7:0]        out_map_q, out_map_d;
  logic [1:0]        out_code_q, out_code_d;

  logic              raw_we, raw_re, ck_we, ck_re;
  logic [AddrW-1:0]  raw_waddr, raw_raddr, ck_waddr, ck_raddr;
  logic [RawW-1:0]   raw_wdata, raw_rdata;
  logic [7:0]        ck_wdata, ck_rdata;

  logic [7:0]        k, k1, fr;
  logic [8:0]        fr_c;
  logic [RawW+8:0]   p1_calc;
  logic [RawW+9:0]   sum_calc;
  logic [RawW-1:0]   r_sel;
  logic [ProdW-1:0]  prod_calc;
  logic [VW-1:0]     v_calc, v_sh;
  logic [7:0]        ck_val;
  logic              s1_move, issue_ok;

  rlpr_ram #(.Width(RawW), .Depth(Depth)) u_raw (
    .clk_i   (clk_i),
    .we_i    (raw_we),
    .waddr_i (raw_waddr),
    .wdata_i (raw_wdata),
    .re_i    (raw_re),
    .raddr_i (raw_raddr),
    .rdata_o (raw_rdata)
  );

  rlpr_ram #(.Width(8), .Depth(Depth)) u_cooked (
    .clk_i   (clk_i),
    .we_i    (ck_we),
    .waddr_i (ck_waddr),
    .wdata_i (ck_wdata),
    .re_i    (ck_re),
    .raddr_i (ck_raddr),
    .rdata_o (ck_rdata)
  );

  assign k    = t_q[15:8];
  assign fr   = t_q[7:0];
  assign k1   = (k >= nm1_q) ? nm1_q : k + 8'd1;
  assign fr_c = 9'd256 - {1'b0, fr};

  assign p1_calc  = {9'b0, a_q} * {{RawW{1'b0}}, fr_c};
  assign sum_calc = {1'b0, p1_q} + ({10'b0, b_q} * {{(RawW+2){1'b0}}, fr})
                  + (RawW+10)'(128);

  assign r_sel     = (tbl_q == '0) ? OneQ : raw_rdata;
  assign prod_calc = {{RawW{1'b0}}, g_q} * {{RawW{1'b0}}, r_sel};
  assign v_calc    = {prod_q, 8'b0} - {8'b0, prod_q} + HalfV;
  assign v_sh      = v_calc >> (2*FRAC_BITS);
  assign ck_val    = (v_sh > VW'(255)) ? 8'hff : v_sh[7:0];

  assign s1_move  = s1_valid_q && (!out_valid_q || m_ready_i);
  assign issue_ok = !s1_valid_q || s1_move;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    i_d         = i_q;
    t_d         = t_q;
    nm1_d       = nm1_q;
    f_d         = f_q;
    tbl_d       = tbl_q;
    a_d         = a_q;
    b_d         = b_q;
    g_d         = g_q;
    p1_d        = p1_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    s1_valid_d  = s1_move ? 1'b0 : s1_valid_q;
    s1_is_d     = s1_is_q;
    s1_code_d   = s1_code_q;
    out_valid_d = out_valid_q;
    out_map_d   = out_map_q;
    out_code_d  = out_code_q;
    out_is_d    = out_is_q;
    pop_o       = 1'b0;
    pb_re_o     = 1'b0;
    pb_raddr_o  = k;
    raw_we      = 1'b0;
    raw_waddr   = {f_q, i_q};
    raw_wdata   = sum_q[RawW+7:8];
    raw_re      = 1'b0;
    raw_raddr   = {{TblW{1'b0}}, i_q};
    ck_we       = 1'b0;
    ck_waddr    = {tbl_q, i_q};
    ck_wdata    = ck_val;
    ck_re       = 1'b0;
    ck_raddr    = {cmd_i.tbl[TblW-1:0], cmd_i.pix};
    stat_o      = '0;

    if (s1_move) begin
      out_valid_d = 1'b1;
      out_map_d   = s1_is_q ? 8'd0 : ck_rdata;
      out_code_d  = s1_code_q;
      out_is_d    = s1_is_q;
    end else if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rlpr_pkg::ST_CLEAR: begin
        stat_o.clearing = 1'b1;
        raw_we    = 1'b1;
        raw_waddr = clr_q;
        raw_wdata = OneQ;
        ck_we     = 1'b1;
        ck_waddr  = clr_q;
        ck_wdata  = clr_q[7:0];
        if (clr_q == AddrW'(Depth-1)) begin
          state_d = rlpr_pkg::ST_RUN;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      rlpr_pkg::ST_RUN: begin
        if (!empty_i && issue_ok) begin
          pop_o = 1'b1;
          if (cmd_i.kind == rlpr_pkg::KIND_PIXEL) begin
            ck_re      = 1'b1;
            s1_valid_d = 1'b1;
            s1_is_d    = 1'b0;
            s1_code_d  = rlpr_pkg::STATUS_OK;
          end else if (cmd_i.status != rlpr_pkg::STATUS_OK) begin
            s1_valid_d       = 1'b1;
            s1_is_d          = 1'b1;
            s1_code_d        = cmd_i.status;
            stat_o.load_done = 1'b1;
          end else begin
            f_d     = cmd_i.tbl[TblW-1:0];
            nm1_d   = cmd_i.nm1;
            i_d     = '0;
            t_d     = '0;
            state_d = rlpr_pkg::ST_RB_A;
          end
        end
      end
      rlpr_pkg::ST_RB_A: begin
        pb_re_o    = 1'b1;
        pb_raddr_o = k;
        state_d    = rlpr_pkg::ST_RB_B;
      end
      rlpr_pkg::ST_RB_B: begin
        pb_re_o    = 1'b1;
        pb_raddr_o = k1;
        a_d        = pb_rdata_i;
        state_d    = rlpr_pkg::ST_RB_C;
      end
      rlpr_pkg::ST_RB_C: begin
        b_d     = pb_rdata_i;
        p1_d    = p1_calc;
        state_d = rlpr_pkg::ST_RB_S;
      end
      rlpr_pkg::ST_RB_S: begin
        sum_d   = sum_calc;
        state_d = rlpr_pkg::ST_RB_W;
      end
      rlpr_pkg::ST_RB_W: begin
        raw_we = 1'b1;
        t_d    = t_q + {8'b0, nm1_q};
        i_d    = i_q + 8'd1;
        if (i_q == 8'hff) begin
          tbl_d   = f_q;
          state_d = rlpr_pkg::ST_CK_A;
        end else begin
          state_d = rlpr_pkg::ST_RB_A;
        end
      end
      rlpr_pkg::ST_CK_A: begin
        raw_re    = 1'b1;
        raw_raddr = {{TblW{1'b0}}, i_q};
        state_d   = rlpr_pkg::ST_CK_B;
      end
      rlpr_pkg::ST_CK_B: begin
        raw_re    = 1'b1;
        raw_raddr = {tbl_q, i_q};
        g_d       = raw_rdata;
        state_d   = rlpr_pkg::ST_CK_C;
      end
      rlpr_pkg::ST_CK_C: begin
        prod_d  = prod_calc;
        state_d = rlpr_pkg::ST_CK_S;
      end
      rlpr_pkg::ST_CK_S: begin
        ck_we = 1'b1;
        i_d   = i_q + 8'd1;
        if (i_q != 8'hff) begin
          state_d = rlpr_pkg::ST_CK_A;
        end else if (f_q == '0 && tbl_q != TblW'(TABLE_COUNT-1)) begin
          tbl_d   = tbl_q + 1'b1;
          state_d = rlpr_pkg::ST_CK_A;
        end else begin
          state_d = rlpr_pkg::ST_STATUS;
        end
      end
      rlpr_pkg::ST_STATUS: begin
        if (issue_ok) begin
          s1_valid_d       = 1'b1;
          s1_is_d          = 1'b1;
          s1_code_d        = rlpr_pkg::STATUS_OK;
          stat_o.load_done = 1'b1;
          state_d          = rlpr_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = rlpr_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlpr_pkg::ST_CLEAR;
      clr_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    t_q        <= t_d;
    nm1_q      <= nm1_d;
    f_q        <= f_d;
    tbl_q      <= tbl_d;
    a_q        <= a_d;
    b_q        <= b_d;
    g_q        <= g_d;
    p1_q       <= p1_d;
    sum_q      <= sum_d;
    prod_q     <= prod_d;
    s1_is_q    <= s1_is_d;
    s1_code_q  <= s1_code_d;
    out_map_q  <= out_map_d;
    out_code_q <= out_code_d;
    out_is_q   <= out_is_d;
  end

  assign m_valid_o   = out_valid_q;
  assign mapped_o    = out_map_q;
  assign status_o    = out_code_q;
  assign is_status_o = out_is_q;

endmodule

[design/region_lut_pixel_remap_top.sv]
// ----------------------------------------------------------------------------
// region_lut_pixel_remap_top
// region-selected lookup-table pixel remap with breakpoint table loading
// ----------------------------------------------------------------------------
// Pixel words are remapped at one per cycle, unless the output is held by
// back-pressure, through a cooked table chosen by the low region bits, via a
// registered read of the cooked table memory and then the output register.
// Breakpoint words are taken one per cycle while the input is ready. The last
// breakpoint of a load starts the rebuild sequencer: states RB_A to RB_W
// interpolate each of 256 raw entries (two point-buffer reads on one port),
// then CK_A to CK_S cook each entry (two raw memory reads on one port) of one
// table for a region filter or all TABLE_COUNT for the global one, taking no
// word meanwhile. After reset a clearing pass over TABLE_COUNT*256 entries
// fills the raw and cooked memories before the first word is accepted.
// ----------------------------------------------------------------------------
module region_lut_pixel_remap_top #(
  parameter int TABLE_COUNT = rlpr_pkg::TABLE_COUNT_DEF,
  parameter int FRAC_BITS   = rlpr_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // pixel_value, region, filter_select, point_value, zero fill
  input  logic [47:0] s_axis_tdata_i,
  // op
  input  logic        s_axis_tuser_i,
  // last_point
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // mapped_value, load_status, zero fill
  output logic [15:0] m_axis_tdata_o,
  // is_status
  output logic        m_axis_tuser_o
);

  localparam int RawW = rlpr_pkg::raw_width(FRAC_BITS);

  rlpr_pkg::back_stat_t back_stat;
  rlpr_pkg::cmd_t       q_in, q_out;
  logic                 q_push, q_pop, q_full, q_empty;
  logic                 pb_we, pb_re;
  logic [7:0]           pb_waddr, pb_raddr;
  logic [RawW-1:0]      pb_wdata, pb_rdata;
  logic [7:0]           mapped;
  logic [1:0]           status;

  rlpr_front #(.TABLE_COUNT(TABLE_COUNT), .FRAC_BITS(FRAC_BITS), .RawW(RawW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .op_i        (s_axis_tuser_i),
    .pixel_i     (s_axis_tdata_i[7:0]),
    .region_i    (s_axis_tdata_i[15:8]),
    .filter_i    (s_axis_tdata_i[23:16]),
    .point_i     (s_axis_tdata_i[40:24]),
    .last_i      (s_axis_tlast_i),
    .back_stat_i (back_stat),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_in),
    .pb_we_o     (pb_we),
    .pb_waddr_o  (pb_waddr),
    .pb_wdata_o  (pb_wdata)
  );

  rlpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rlpr_ram #(.Width(RawW), .Depth(rlpr_pkg::MAX_POINTS)) u_points (
    .clk_i   (clk_i),
    .we_i    (pb_we),
    .waddr_i (pb_waddr),
    .wdata_i (pb_wdata),
    .re_i    (pb_re),
    .raddr_i (pb_raddr),
    .rdata_o (pb_rdata)
  );

  rlpr_back #(.TABLE_COUNT(TABLE_COUNT), .FRAC_BITS(FRAC_BITS), .RawW(RawW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_out),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .pb_re_o     (pb_re),
    .pb_raddr_o  (pb_raddr),
    .pb_rdata_i  (pb_rdata),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .mapped_o    (mapped),
    .status_o    (status),
    .is_status_o (m_axis_tuser_o),
    .stat_o      (back_stat)
  );

  assign m_axis_tdata_o = {6'b0, status, mapped};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.clearing |-> !s_axis_tready_o)
    else $error("word accepted during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[7:0] == 8'd0))
    else $error("status result carries a mapped value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[9:8] == 2'd0))
    else $error("pixel result carries a load status");

endmodule
